[rtl/core/gram_schmidt_orthonormalizer_assert.svh]
// Assertion macros for the Gram-Schmidt orthonormalizer.
// Expects clk and rst_n in the scope where a macro is used.
`ifndef GRAM_SCHMIDT_ORTHONORMALIZER_ASSERT_SVH
`define GRAM_SCHMIDT_ORTHONORMALIZER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define GSO_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gso check failed: same-cycle implication");

// Consequent must hold in the cycle after the antecedent.
`define GSO_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gso check failed: next-cycle implication");

`endif

[rtl/core/gso_pkg.sv]
// Shared types and constants of the Gram-Schmidt orthonormalizer.
// No dependencies; used by every module of the block but gso_matrix_mem.
`default_nettype none
package gso_pkg;

  localparam int DEF_MAX_ROWS = 64;
  localparam int DEF_MAX_COLS = 16;

  localparam int Q_W      = 32;
  localparam int PROD_W   = 64;
  localparam int ROOT_W   = 32;
  localparam int DIVD_W   = 48;
  localparam int KEPT_W   = 5;
  localparam int ROWS_W   = 7;
  localparam int COLS_W   = 5;
  localparam int EPS_W    = 16;
  localparam int CFG_IDX_W = 2;

  localparam logic [ROWS_W-1:0] ROWS_RESET = 7'd64;
  localparam logic [COLS_W-1:0] COLS_RESET = 5'd16;
  localparam logic [EPS_W-1:0]  EPS_RESET  = 16'd7;

  localparam logic [1:0] REQ_WRITE = 2'd0;
  localparam logic [1:0] REQ_START = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_USED = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS_USED = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EPS       = 2'd2;

  localparam logic RES_READ = 1'b0;
  localparam logic RES_DONE = 1'b1;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [5:0]         row_index;
    logic [3:0]         col_index;
    logic signed [31:0] entry_value;
  } in_item_t;

  typedef struct packed {
    logic               result_kind;
    logic signed [31:0] read_value;
    logic [4:0]         columns_kept;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_COL,
    ST_DOT,
    ST_DOT_DRAIN,
    ST_UPD,
    ST_UPD_DRAIN,
    ST_SSQ,
    ST_SSQ_DRAIN,
    ST_SQRT,
    ST_CHK,
    ST_SCL_RD,
    ST_SCL_WAIT,
    ST_SCL_DIV,
    ST_ZERO,
    ST_DONE
  } gso_state_t;

endpackage
`default_nettype wire

[rtl/core/gso_matrix_mem.sv]
// Column store: one write port and two registered read ports.
// Uses no package items; sized by the top level.
`default_nettype none
module gso_matrix_mem #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [31:0]   wr_data,
  input  wire logic [AW-1:0] rd_a_addr,
  input  wire logic [AW-1:0] rd_b_addr,
  output logic [31:0]        rd_a_data,
  output logic [31:0]        rd_b_data
);

  logic [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_a_data <= mem[rd_a_addr];
    rd_b_data <= mem[rd_b_addr];
  end

endmodule
`default_nettype wire

[rtl/core/gso_isqrt.sv]
// Floor square root of a 64-bit value, one result bit per cycle.
// Depends on gso_pkg for widths.
`default_nettype none
module gso_isqrt (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic [gso_pkg::PROD_W-1:0]    radicand,
  output logic                               done,
  output logic [gso_pkg::ROOT_W-1:0]         root
);

  localparam int CW = $clog2(gso_pkg::ROOT_W);

  logic                        busy_r, done_r;
  logic [CW-1:0]               cnt_r;
  logic [gso_pkg::PROD_W-1:0]  rad_r;
  logic [gso_pkg::ROOT_W-1:0]  root_r;
  logic [gso_pkg::ROOT_W+1:0]  rem_r;
  logic [gso_pkg::ROOT_W+2:0]  rem_sh, trial;
  logic                        ge;

  // Two radicand bits enter the partial remainder per step.
  assign rem_sh = {rem_r[gso_pkg::ROOT_W:0], rad_r[gso_pkg::PROD_W-1 -: 2]};
  assign trial  = {1'b0, root_r, 2'b01};
  assign ge     = rem_sh >= trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(gso_pkg::ROOT_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= radicand;
      root_r <= '0;
      rem_r  <= '0;
    end else if (busy_r) begin
      rad_r  <= {rad_r[gso_pkg::PROD_W-3:0], 2'b00};
      root_r <= {root_r[gso_pkg::ROOT_W-2:0], ge};
      rem_r  <= ge ? (gso_pkg::ROOT_W+2)'(rem_sh - trial) : rem_sh[gso_pkg::ROOT_W+1:0];
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule
`default_nettype wire

[rtl/core/gso_divider.sv]
// Restoring unsigned divider, 48-bit dividend by 32-bit divisor, one bit per cycle.
// Depends on gso_pkg for widths.
`default_nettype none
module gso_divider (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [gso_pkg::DIVD_W-1:0]  dividend,
  input  wire logic [gso_pkg::Q_W-1:0]     divisor,
  output logic                             done,
  output logic [gso_pkg::DIVD_W-1:0]       quotient
);

  localparam int CW = $clog2(gso_pkg::DIVD_W);

  logic                        busy_r, done_r;
  logic [CW-1:0]               cnt_r;
  logic [gso_pkg::DIVD_W-1:0]  quo_r;
  logic [gso_pkg::Q_W-1:0]     rem_r, div_r;
  logic [gso_pkg::Q_W:0]       rem_sh;
  logic                        ge;

  assign rem_sh = {rem_r, quo_r[gso_pkg::DIVD_W-1]};
  assign ge     = rem_sh >= {1'b0, div_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(gso_pkg::DIVD_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // The quotient register doubles as the dividend shifter.
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      div_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[gso_pkg::DIVD_W-2:0], ge};
      rem_r <= ge ? gso_pkg::Q_W'(rem_sh - {1'b0, div_r}) : rem_sh[gso_pkg::Q_W-1:0];
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule
`default_nettype wire

[rtl/core/gram_schmidt_orthonormalizer.sv]
// Top level: sequencer, multiply pipeline and register file of the orthonormalizer.
// Depends on gso_pkg, gso_matrix_mem, gso_isqrt, gso_divider and the assert header.
//
// Channel  Ports                                 Direction  Handshake
// input    start, busy, in_data                  in         start & !busy
// result   out_valid, out_data                   out        one-cycle strobe
// config   cfg_valid, cfg_ready, cfg_index/data  in         valid & ready
//
// A read beat returns its result in the next cycle. A start beat holds busy while,
// for each column in use, a dot and an update sweep run over its rows against each
// earlier column and a square sweep against itself, each sweep followed by a drain of
// the multiply pipeline; then come the square root and the scaling of each entry by the
// divider. A pass stopping on a degenerate column clears it and every later one instead.
// Reset is synchronous; the store keeps its contents and needs no clearing pass.
// Results are never held off: each appears for exactly one cycle.
`default_nettype none
`include "gram_schmidt_orthonormalizer_assert.svh"
module gram_schmidt_orthonormalizer #(
  parameter int MAX_ROWS = gso_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS = gso_pkg::DEF_MAX_COLS
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire gso_pkg::in_item_t                 in_data,
  output logic                                   out_valid,
  output gso_pkg::out_item_t                     out_data,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [gso_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [gso_pkg::EPS_W-1:0]         cfg_data
);

  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int RCW   = $clog2(MAX_ROWS + 1);
  localparam int CCW   = $clog2(MAX_COLS + 1);

  gso_pkg::gso_state_t state_r, state_nxt;

  logic [gso_pkg::ROWS_W-1:0] rows_used_r;
  logic [gso_pkg::COLS_W-1:0] cols_used_r;
  logic [gso_pkg::EPS_W-1:0]  eps_r;

  logic [CCW-1:0] i_r, i_nxt, j_r, j_nxt;
  logic [RCW-1:0] k_r, k_nxt;
  logic [gso_pkg::KEPT_W-1:0] kept_r, kept_nxt;

  logic [RCW-1:0] nr, nr_m1;
  logic [CCW-1:0] nc, nc_m1;

  logic in_acc, in_inside;
  logic rd_pend_r, rd_in_r;

  logic          wr_en;
  logic [AW-1:0] wr_addr, rd_a_addr, rd_b_addr, in_addr;
  logic [31:0]   wr_data, rd_a_data, rd_b_data;

  logic           issue;
  logic           p1_v_r, p2_v_r;
  logic [RCW-1:0] p1_k_r, p2_k_r;
  logic signed [gso_pkg::PROD_W-1:0] prod, prod_r;
  logic signed [31:0] mul_a, mul_b, x2_r, r_r, rq, upd_val;
  logic signed [gso_pkg::PROD_W-1:0] acc_r;
  logic [gso_pkg::PROD_W-1:0]        ssq_r;
  logic ph_dot, ph_upd, ph_ssq, drain_done;

  logic                        sqrt_start, sqrt_done;
  logic [gso_pkg::ROOT_W-1:0]  norm;
  logic                        degenerate;

  logic                        div_start, div_done;
  logic [gso_pkg::DIVD_W-1:0]  dividend, quotient;
  logic [31:0]                 mag;
  logic                        neg_r;
  logic signed [31:0]          scaled;

  function automatic logic [AW-1:0] addr_of(input logic [CCW-1:0] c,
                                            input logic [RCW-1:0] r);
    return AW'(AW'(c) * AW'(MAX_ROWS) + AW'(r));
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sh0000_0000_7FFF_FFFF) return 32'sh7FFF_FFFF;
    if (v < -64'sh0000_0000_8000_0000) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) return s[64] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
    return s[63:0];
  endfunction

  // Configuration and clamped sizes.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_used_r <= gso_pkg::ROWS_RESET;
      cols_used_r <= gso_pkg::COLS_RESET;
      eps_r       <= gso_pkg::EPS_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        gso_pkg::CFG_ROWS_USED: rows_used_r <= cfg_data[gso_pkg::ROWS_W-1:0];
        gso_pkg::CFG_COLS_USED: cols_used_r <= cfg_data[gso_pkg::COLS_W-1:0];
        gso_pkg::CFG_EPS:       eps_r       <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (rows_used_r == '0) begin
      nr = RCW'(1);
    end else if (32'(rows_used_r) > 32'(MAX_ROWS)) begin
      nr = RCW'(MAX_ROWS);
    end else begin
      nr = RCW'(rows_used_r);
    end
    if (cols_used_r == '0) begin
      nc = CCW'(1);
    end else if (32'(cols_used_r) > 32'(MAX_COLS)) begin
      nc = CCW'(MAX_COLS);
    end else begin
      nc = CCW'(cols_used_r);
    end
  end
  assign nr_m1 = nr - 1'b1;
  assign nc_m1 = nc - 1'b1;

  // Item side.
  assign busy      = state_r != gso_pkg::ST_IDLE;
  assign in_acc    = start && !busy;
  assign in_inside = (32'(in_data.row_index) < 32'(MAX_ROWS)) &&
                     (32'(in_data.col_index) < 32'(MAX_COLS));
  assign in_addr   = AW'(AW'(in_data.col_index) * AW'(MAX_ROWS) + AW'(in_data.row_index));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_pend_r <= 1'b0;
    end else begin
      rd_pend_r <= in_acc && (in_data.req_type == gso_pkg::REQ_READ);
    end
  end

  always_ff @(posedge clk) begin
    rd_in_r <= in_inside;
  end

  assign out_valid             = rd_pend_r || (state_r == gso_pkg::ST_DONE);
  assign out_data.result_kind  = (state_r == gso_pkg::ST_DONE) ? gso_pkg::RES_DONE
                                                               : gso_pkg::RES_READ;
  assign out_data.read_value   = (rd_pend_r && rd_in_r) ? rd_a_data : '0;
  assign out_data.columns_kept = (state_r == gso_pkg::ST_DONE) ? kept_r : '0;

  // Phases of the shared multiply pipeline.
  assign ph_dot = state_r inside {gso_pkg::ST_DOT, gso_pkg::ST_DOT_DRAIN};
  assign ph_upd = state_r inside {gso_pkg::ST_UPD, gso_pkg::ST_UPD_DRAIN};
  assign ph_ssq = state_r inside {gso_pkg::ST_SSQ, gso_pkg::ST_SSQ_DRAIN};
  assign drain_done = !p1_v_r && !p2_v_r;

  assign degenerate = (norm == '0) || (norm < {16'b0, eps_r});

  // Next state and loop counters.
  always_comb begin
    state_nxt = state_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    k_nxt     = k_r;
    kept_nxt  = kept_r;
    case (state_r)
      gso_pkg::ST_IDLE: begin
        if (in_acc && (in_data.req_type == gso_pkg::REQ_START)) begin
          state_nxt = gso_pkg::ST_COL;
          i_nxt     = '0;
        end
      end
      gso_pkg::ST_COL: begin
        j_nxt = '0;
        k_nxt = '0;
        if (i_r == nc) begin
          kept_nxt  = gso_pkg::KEPT_W'(i_r);
          state_nxt = gso_pkg::ST_DONE;
        end else if (i_r == '0) begin
          state_nxt = gso_pkg::ST_SSQ;
        end else begin
          state_nxt = gso_pkg::ST_DOT;
        end
      end
      gso_pkg::ST_DOT, gso_pkg::ST_UPD, gso_pkg::ST_SSQ: begin
        if (k_r == nr_m1) begin
          k_nxt = '0;
          case (state_r)
            gso_pkg::ST_DOT: state_nxt = gso_pkg::ST_DOT_DRAIN;
            gso_pkg::ST_UPD: state_nxt = gso_pkg::ST_UPD_DRAIN;
            default:         state_nxt = gso_pkg::ST_SSQ_DRAIN;
          endcase
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end
      gso_pkg::ST_DOT_DRAIN: begin
        if (drain_done) state_nxt = gso_pkg::ST_UPD;
      end
      gso_pkg::ST_UPD_DRAIN: begin
        if (drain_done) begin
          j_nxt = j_r + 1'b1;
          if (CCW'(j_r + 1'b1) == i_r) begin
            state_nxt = gso_pkg::ST_SSQ;
          end else begin
            state_nxt = gso_pkg::ST_DOT;
          end
        end
      end
      gso_pkg::ST_SSQ_DRAIN: begin
        if (drain_done) state_nxt = gso_pkg::ST_SQRT;
      end
      gso_pkg::ST_SQRT: begin
        if (sqrt_done) state_nxt = gso_pkg::ST_CHK;
      end
      gso_pkg::ST_CHK: begin
        k_nxt = '0;
        if (degenerate) begin
          j_nxt     = i_r;
          kept_nxt  = gso_pkg::KEPT_W'(i_r);
          state_nxt = gso_pkg::ST_ZERO;
        end else begin
          state_nxt = gso_pkg::ST_SCL_RD;
        end
      end
      gso_pkg::ST_SCL_RD:   state_nxt = gso_pkg::ST_SCL_WAIT;
      gso_pkg::ST_SCL_WAIT: state_nxt = gso_pkg::ST_SCL_DIV;
      gso_pkg::ST_SCL_DIV: begin
        if (div_done) begin
          if (k_r == nr_m1) begin
            k_nxt     = '0;
            i_nxt     = i_r + 1'b1;
            state_nxt = gso_pkg::ST_COL;
          end else begin
            k_nxt     = k_r + 1'b1;
            state_nxt = gso_pkg::ST_SCL_RD;
          end
        end
      end
      gso_pkg::ST_ZERO: begin
        if (k_r == nr_m1) begin
          k_nxt = '0;
          if (j_r == nc_m1) begin
            state_nxt = gso_pkg::ST_DONE;
          end else begin
            j_nxt = j_r + 1'b1;
          end
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end
      gso_pkg::ST_DONE: state_nxt = gso_pkg::ST_IDLE;
      default:          state_nxt = gso_pkg::ST_IDLE;
    endcase
  end

  // Memory and unit controls.
  always_comb begin
    rd_a_addr  = busy ? addr_of(i_r, k_r) : in_addr;
    rd_b_addr  = addr_of(j_r, k_r);
    issue      = state_r inside {gso_pkg::ST_DOT, gso_pkg::ST_UPD, gso_pkg::ST_SSQ};
    sqrt_start = (state_r == gso_pkg::ST_SSQ_DRAIN) && drain_done;
    div_start  = state_r == gso_pkg::ST_SCL_WAIT;
    wr_en      = 1'b0;
    wr_addr    = in_addr;
    wr_data    = in_data.entry_value;
    case (state_r)
      gso_pkg::ST_IDLE: begin
        wr_en = in_acc && in_inside && (in_data.req_type == gso_pkg::REQ_WRITE);
      end
      gso_pkg::ST_UPD, gso_pkg::ST_UPD_DRAIN: begin
        wr_en   = p2_v_r;
        wr_addr = addr_of(i_r, p2_k_r);
        wr_data = upd_val;
      end
      gso_pkg::ST_SCL_DIV: begin
        wr_en   = div_done;
        wr_addr = addr_of(i_r, k_r);
        wr_data = scaled;
      end
      gso_pkg::ST_ZERO: begin
        wr_en   = 1'b1;
        wr_addr = addr_of(j_r, k_r);
        wr_data = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gso_pkg::ST_IDLE;
      i_r     <= '0;
      j_r     <= '0;
      k_r     <= '0;
      kept_r  <= '0;
      p1_v_r  <= 1'b0;
      p2_v_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      k_r     <= k_nxt;
      kept_r  <= kept_nxt;
      p1_v_r  <= issue;
      p2_v_r  <= p1_v_r;
    end
  end

  // Multiply stage: column i against column j, projection against column j,
  // or column i squared.
  always_comb begin
    mul_a = rd_a_data;
    mul_b = rd_b_data;
    if (ph_upd) begin
      mul_a = r_r;
    end else if (ph_ssq) begin
      mul_b = rd_a_data;
    end
  end
  assign prod = mul_a * mul_b;

  // Projection coefficient: round half up to Q16.16, then saturate.
  always_comb begin
    logic signed [63:0] t;
    t  = sat_add64(acc_r, 64'sd32768);
    rq = sat32(t >>> 16);
  end

  // Update: x - round(r*y); the product is far from overflow, so no
  // saturation is needed on the rounding add.
  always_comb begin
    logic signed [63:0] t;
    t       = (prod_r + 64'sd32768) >>> 16;
    upd_val = sat32(64'(x2_r) - t);
  end

  always_ff @(posedge clk) begin
    p1_k_r <= k_r;
    p2_k_r <= p1_k_r;
    prod_r <= prod;
    x2_r   <= rd_a_data;
    if (!ph_dot) begin
      acc_r <= '0;
    end else if (p2_v_r) begin
      acc_r <= sat_add64(acc_r, prod_r);
    end
    if (!ph_ssq) begin
      ssq_r <= '0;
    end else if (p2_v_r) begin
      ssq_r <= (({1'b0, ssq_r} + {1'b0, prod_r}) > 65'({64{1'b1}})) ? {64{1'b1}}
               : ssq_r + prod_r;
    end
    if ((state_r == gso_pkg::ST_DOT_DRAIN) && drain_done) begin
      r_r <= rq;
    end
    if (state_r == gso_pkg::ST_SCL_WAIT) begin
      neg_r <= rd_a_data[31];
    end
  end

  // Scaling: (|x|<<16 + norm/2) / norm, signed and saturated.
  assign mag      = rd_a_data[31] ? 32'(-rd_a_data) : rd_a_data;
  assign dividend = {mag, 16'b0} + gso_pkg::DIVD_W'(norm >> 1);

  always_comb begin
    if (!neg_r) begin
      scaled = (quotient > 48'h0000_7FFF_FFFF) ? 32'sh7FFF_FFFF : quotient[31:0];
    end else begin
      scaled = (quotient >= 48'h0000_8000_0000) ? 32'sh8000_0000 : -quotient[31:0];
    end
  end

  gso_matrix_mem #(
    .DEPTH(DEPTH),
    .AW   (AW)
  ) u_mem (
    .clk      (clk),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .rd_a_addr(rd_a_addr),
    .rd_b_addr(rd_b_addr),
    .rd_a_data(rd_a_data),
    .rd_b_data(rd_b_data)
  );

  gso_isqrt u_isqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (sqrt_start),
    .radicand(ssq_r),
    .done    (sqrt_done),
    .root    (norm)
  );

  gso_divider u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .dividend(dividend),
    .divisor (norm),
    .done    (div_done),
    .quotient(quotient)
  );

  `GSO_ASSERT_SAME(a_no_result_clash, rd_pend_r, state_r != gso_pkg::ST_DONE)
  `GSO_ASSERT_NEXT(a_done_to_idle, state_r == gso_pkg::ST_DONE, state_r == gso_pkg::ST_IDLE)
  `GSO_ASSERT_SAME(a_div_in_scale, div_done, state_r == gso_pkg::ST_SCL_DIV)
  `GSO_ASSERT_SAME(a_sqrt_in_wait, sqrt_done, state_r == gso_pkg::ST_SQRT)
  `GSO_ASSERT_NEXT(a_pipe_flow, p1_v_r, p2_v_r)

endmodule
`default_nettype wire

[tb/gram_schmidt_orthonormalizer_tb.sv]
// Self-checking testbench of the Gram-Schmidt orthonormalizer: a directed table, then random
// matrices loaded, orthonormalized and read back, checked per the table or a bench predictor.
// Depends on gso_pkg and the gram_schmidt_orthonormalizer RTL.
`timescale 1ns / 1ps
module gram_schmidt_orthonormalizer_tb;

  localparam int NROWS = 64;
  localparam int NCOLS = 16;
  localparam int TARGET_ITEMS = 2000;
  localparam longint CYCLE_LIMIT = 3000000;
  // Request code that the block must ignore.
  localparam logic [1:0] REQ_UNKNOWN = 2'd3;

  typedef struct {
    gso_pkg::in_item_t  item;
    bit                 typed;
    gso_pkg::out_item_t exp;
  } dir_row_t;

  logic                          clk;
  logic                          rst_n;
  logic                          start;
  logic                          busy;
  gso_pkg::in_item_t             in_data;
  logic                          out_valid;
  gso_pkg::out_item_t            out_data;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [gso_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [gso_pkg::EPS_W-1:0]     cfg_data;

  gram_schmidt_orthonormalizer u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Shadow copy of the block's matrix and registers.
  logic signed [31:0]         shadow_mat[NROWS*NCOLS];
  bit                         written[NROWS*NCOLS];
  logic [gso_pkg::ROWS_W-1:0] sh_rows;
  logic [gso_pkg::COLS_W-1:0] sh_cols;
  logic [gso_pkg::EPS_W-1:0]  sh_eps;

  gso_pkg::out_item_t pending_results[$];
  dir_row_t  dir_tab[$];
  int        errors;
  int        n_items;
  int        n_starts;
  int        n_reads;
  int        n_degenerate;
  longint    cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------- arithmetic
  function automatic longint sat_add(longint a, longint b);
    logic [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) return s[64] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
    return longint'(s[63:0]);
  endfunction

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint round_q(longint v);
    return sat_add(v, 64'sd32768) >>> 16;
  endfunction

  function automatic longint unsigned floor_sqrt(longint unsigned s);
    longint unsigned res;
    longint unsigned bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > s) bitv >>= 2;
    while (bitv != 0) begin
      if (s >= res + bitv) begin
        s -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint ent(int r, int c);
    return longint'(shadow_mat[c*NROWS + r]);
  endfunction

  function automatic void put(int r, int c, longint v);
    shadow_mat[c*NROWS + r] = 32'(sat32(v));
  endfunction

  // Modified Gram-Schmidt over the shadow matrix; returns the number of columns kept.
  function automatic int orthonormalize_shadow();
    int nr, nc;
    longint acc, proj, x;
    longint unsigned sumsq, p, norm, mag, q;
    nr = (sh_rows < 1) ? 1 : (sh_rows > NROWS) ? NROWS : int'(sh_rows);
    nc = (sh_cols < 1) ? 1 : (sh_cols > NCOLS) ? NCOLS : int'(sh_cols);
    for (int i = 0; i < nc; i++) begin
      for (int j = 0; j < i; j++) begin
        acc = 0;
        for (int k = 0; k < nr; k++) acc = sat_add(acc, ent(k, i) * ent(k, j));
        proj = sat32(round_q(acc));
        for (int k = 0; k < nr; k++) put(k, i, ent(k, i) - round_q(proj * ent(k, j)));
      end
      sumsq = 0;
      for (int k = 0; k < nr; k++) begin
        x = ent(k, i);
        p = longint'(x * x);
        sumsq = (sumsq > 64'hFFFF_FFFF_FFFF_FFFF - p) ? 64'hFFFF_FFFF_FFFF_FFFF : sumsq + p;
      end
      norm = floor_sqrt(sumsq);
      if (norm == 0 || norm < longint'(sh_eps)) begin
        for (int j = i; j < nc; j++)
          for (int k = 0; k < nr; k++) put(k, j, 0);
        return i;
      end
      for (int k = 0; k < nr; k++) begin
        x = ent(k, i);
        mag = (x < 0) ? longint'(-x) : longint'(x);
        q = ((mag << 16) + norm / 2) / norm;
        put(k, i, (x < 0) ? -longint'(q) : longint'(q));
      end
    end
    return nc;
  endfunction

  // Updates the shadow state for one accepted beat; returns 1 when a result is due.
  function automatic bit predict_request(gso_pkg::in_item_t it, output gso_pkg::out_item_t res);
    int idx;
    idx = int'(it.col_index) * NROWS + int'(it.row_index);
    res = '0;
    case (it.req_type)
      gso_pkg::REQ_WRITE: begin
        shadow_mat[idx] = it.entry_value;
        written[idx] = 1'b1;
        return 1'b0;
      end
      gso_pkg::REQ_START: begin
        res.result_kind  = gso_pkg::RES_DONE;
        res.columns_kept = 5'(orthonormalize_shadow());
        return 1'b1;
      end
      gso_pkg::REQ_READ: begin
        res.result_kind = gso_pkg::RES_READ;
        res.read_value  = shadow_mat[idx];
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  // ---------------------------------------------------------------- checking
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result beat: kind %0d value %0h kept %0d",
               out_data.result_kind, out_data.read_value, out_data.columns_kept);
        errors++;
      end else begin
        gso_pkg::out_item_t e;
        e = pending_results.pop_front();
        if (out_data.result_kind !== e.result_kind) begin
          $error("result_kind: expected %0d, got %0d", e.result_kind, out_data.result_kind);
          errors++;
        end
        if (out_data.read_value !== e.read_value) begin
          $error("read_value: expected %0h, got %0h", e.read_value, out_data.read_value);
          errors++;
        end
        if (out_data.columns_kept !== e.columns_kept) begin
          $error("columns_kept: expected %0d, got %0d", e.columns_kept, out_data.columns_kept);
          errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------- driving
  function automatic gso_pkg::in_item_t mk(logic [1:0] req, int r, int c,
                                           logic signed [31:0] v);
    gso_pkg::in_item_t it;
    it.req_type    = req;
    it.row_index   = 6'(r);
    it.col_index   = 4'(c);
    it.entry_value = v;
    return it;
  endfunction

  // Called at a rising edge; returns at the edge where the beat was accepted.
  task automatic send(gso_pkg::in_item_t it, bit typed = 1'b0,
                      gso_pkg::out_item_t typed_exp = '0);
    gso_pkg::out_item_t res;
    bit steady;
    steady = (n_items >= 700 && n_items < 1100);
    if (!steady && $urandom_range(0, 99) < 25) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (busy);
    if (predict_request(it, res)) begin
      pending_results.push_back(typed ? typed_exp : res);
      if (it.req_type == gso_pkg::REQ_START) begin
        n_starts++;
        if (res.columns_kept < ((sh_cols < 1) ? 1 : (sh_cols > NCOLS) ? NCOLS : sh_cols))
          n_degenerate++;
      end else begin
        n_reads++;
      end
    end
    if (it.req_type != REQ_UNKNOWN) n_items++;
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [gso_pkg::CFG_IDX_W-1:0] idx,
                           logic [gso_pkg::EPS_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      gso_pkg::CFG_ROWS_USED: sh_rows = data[gso_pkg::ROWS_W-1:0];
      gso_pkg::CFG_COLS_USED: sh_cols = data[gso_pkg::COLS_W-1:0];
      gso_pkg::CFG_EPS:       sh_eps  = data;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic configure(int rows, int cols, int eps);
    drain();
    write_reg(gso_pkg::CFG_ROWS_USED, {9'($urandom), 7'(rows)});
    write_reg(gso_pkg::CFG_COLS_USED, {11'($urandom), 5'(cols)});
    write_reg(gso_pkg::CFG_EPS, 16'(eps));
  endtask

  function automatic logic signed [31:0] pick_value(int style, int r);
    case (style)
      0: return $signed($urandom_range(0, 8 << 16)) - (4 << 16);
      1: return $urandom;
      2: return 32'sd0;
      3: return shadow_mat[r];  // copy of column 0, so the column is dependent
      default: return $signed($urandom_range(0, 6)) - 3;
    endcase
  endfunction

  task automatic noise_item();
    int idx;
    case ($urandom_range(0, 2))
      0: begin
        do idx = $urandom_range(0, NROWS*NCOLS - 1); while (!written[idx]);
        send(mk(gso_pkg::REQ_READ, idx % NROWS, idx / NROWS, $urandom));
      end
      1: send(mk(REQ_UNKNOWN, $urandom_range(0, 63), $urandom_range(0, 15), $urandom));
      default: send(mk(gso_pkg::REQ_WRITE, $urandom_range(0, 63), $urandom_range(0, 15),
                       $urandom));
    endcase
  endtask

  task automatic run_matrix(int rows, int cols, int eps);
    int nr, nc, style;
    configure(rows, cols, eps);
    nr = (rows < 1) ? 1 : (rows > NROWS) ? NROWS : rows;
    nc = (cols < 1) ? 1 : (cols > NCOLS) ? NCOLS : cols;
    for (int c = 0; c < nc; c++) begin
      style = $urandom_range(0, 9);
      style = (style < 5) ? 0 : (style < 7) ? 1 : (style == 7) ? 2 : (style == 8) ? 3 : 4;
      if (c == 0 && style == 3) style = 0;
      for (int r = 0; r < nr; r++) begin
        if ($urandom_range(0, 99) < 12) noise_item();
        send(mk(gso_pkg::REQ_WRITE, r, c, pick_value(style, r)));
      end
    end
    send(mk(gso_pkg::REQ_START, $urandom_range(0, 63), $urandom_range(0, 15), $urandom));
    repeat ($urandom_range(1, (nr * nc < 12) ? nr * nc : 12)) begin
      send(mk(gso_pkg::REQ_READ, $urandom_range(0, nr - 1), $urandom_range(0, nc - 1),
              $urandom));
    end
  endtask

  // ---------------------------------------------------------------- main
  initial begin
    int phase;
    start     <= 1'b0;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    rst_n     <= 1'b0;
    sh_rows = gso_pkg::ROWS_RESET;
    sh_cols = gso_pkg::COLS_RESET;
    sh_eps  = gso_pkg::EPS_RESET;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table on a 2x2 matrix.
    dir_tab.push_back('{mk(gso_pkg::REQ_WRITE, 0, 0, 32'sh7FFF_FFFF), 0, '0});
    dir_tab.push_back('{mk(gso_pkg::REQ_WRITE, 63, 15, 32'sh8000_0000), 0, '0});
    dir_tab.push_back('{mk(gso_pkg::REQ_READ, 0, 0, 0), 1,
                        '{gso_pkg::RES_READ, 32'sh7FFF_FFFF, 5'd0}});
    dir_tab.push_back('{mk(gso_pkg::REQ_READ, 63, 15, 0), 1,
                        '{gso_pkg::RES_READ, 32'sh8000_0000, 5'd0}});
    // An unknown request type must leave the store alone and answer nothing.
    dir_tab.push_back('{mk(REQ_UNKNOWN, 63, 15, 0), 0, '0});
    dir_tab.push_back('{mk(gso_pkg::REQ_READ, 63, 15, 0), 1,
                        '{gso_pkg::RES_READ, 32'sh8000_0000, 5'd0}});
    dir_tab.push_back('{mk(gso_pkg::REQ_WRITE, 0, 0, 0), 0, '0});
    dir_tab.push_back('{mk(gso_pkg::REQ_WRITE, 1, 0, 0), 0, '0});
    dir_tab.push_back('{mk(gso_pkg::REQ_WRITE, 0, 1, 1 << 16), 0, '0});
    dir_tab.push_back('{mk(gso_pkg::REQ_WRITE, 1, 1, 0), 0, '0});
    // A zero first column is degenerate, so everything in use is cleared.
    dir_tab.push_back('{mk(gso_pkg::REQ_START, 0, 0, 0), 1,
                        '{gso_pkg::RES_DONE, 32'sd0, 5'd0}});
    dir_tab.push_back('{mk(gso_pkg::REQ_READ, 0, 1, 0), 1,
                        '{gso_pkg::RES_READ, 32'sd0, 5'd0}});
    dir_tab.push_back('{mk(gso_pkg::REQ_WRITE, 0, 0, 3 << 16), 0, '0});
    dir_tab.push_back('{mk(gso_pkg::REQ_WRITE, 1, 0, 4 << 16), 0, '0});
    dir_tab.push_back('{mk(gso_pkg::REQ_WRITE, 0, 1, 1 << 16), 0, '0});
    dir_tab.push_back('{mk(gso_pkg::REQ_WRITE, 1, 1, 0), 0, '0});
    dir_tab.push_back('{mk(gso_pkg::REQ_START, 0, 0, 0), 0, '0});
    dir_tab.push_back('{mk(gso_pkg::REQ_READ, 0, 0, 0), 0, '0});
    dir_tab.push_back('{mk(gso_pkg::REQ_READ, 1, 0, 0), 0, '0});
    dir_tab.push_back('{mk(gso_pkg::REQ_READ, 0, 1, 0), 0, '0});
    dir_tab.push_back('{mk(gso_pkg::REQ_READ, 1, 1, 0), 0, '0});
    dir_tab.push_back('{mk(gso_pkg::REQ_WRITE, 0, 1, 6 << 16), 0, '0});
    dir_tab.push_back('{mk(gso_pkg::REQ_WRITE, 1, 1, 8 << 16), 0, '0});
    dir_tab.push_back('{mk(gso_pkg::REQ_START, 0, 0, 0), 0, '0});
    dir_tab.push_back('{mk(gso_pkg::REQ_READ, 1, 1, 0), 0, '0});

    configure(2, 2, 7);
    foreach (dir_tab[i]) send(dir_tab[i].item, dir_tab[i].typed, dir_tab[i].exp);

    phase = 0;
    while (n_items < TARGET_ITEMS) begin
      case (phase)
        0: run_matrix(0, 31, 0);           // both counts clamp up to one row, down to 16 columns
        1: run_matrix(64, 16, 7);          // the full store, once
        2: run_matrix(127, 1, 65535);
        3: run_matrix(1, 16, 7);
        default: begin
          int e;
          case ($urandom_range(0, 4))
            0: e = 0;
            1: e = 65535;
            2: e = $urandom_range(0, 65535);
            3: e = $urandom_range(0, 64);
            default: e = 7;
          endcase
          run_matrix($urandom_range(1, 6), $urandom_range(1, 4), e);
        end
      endcase
      phase++;
    end

    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("Ran %0d beats over %0d matrices: %0d reads, %0d orthonormalizations",
             n_items, phase, n_reads, n_starts);
    $display("%0d passes stopped early on a degenerate column", n_degenerate);
    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
